FILE: rtl/core/ketq_pkg.sv
// shared types, widths and codes for the keyed expiring transmit queue
package ketq_pkg;

  localparam int DEPTH     = 64;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ID_W      = 31;
  localparam int EXP_W     = 48;
  localparam int HND_W     = 16;
  localparam int CAP_W     = 7;
  localparam int DROP_W    = 7;
  localparam int ACT_W     = 2;
  localparam int CMP_W     = EXP_W;
  localparam int CAP_RESET = 16;

  localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REM = 2'd1;
  localparam logic [ACT_W-1:0] ACT_GET = 2'd2;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_MISS = 1'b1;

  typedef enum logic {
    SCAN_MIN,
    SCAN_FIND
  } scan_mode_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [EXP_W-1:0] expiry;
    logic [HND_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic            start;
    scan_mode_t      mode;
    logic [ID_W-1:0] key;
  } scan_cmd_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] slot;
    entry_t           ent;
    logic             free_hit;
    logic [IDX_W-1:0] free_slot;
  } scan_res_t;

  typedef struct packed {
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
  } cmp_op_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

FILE: rtl/core/ketq_in_if.sv
// request channel: valid/ready plus one request word
interface ketq_in_if;
  logic                        valid;
  logic                        ready;
  logic [ketq_pkg::ACT_W-1:0]  action;
  logic [ketq_pkg::ID_W-1:0]   msg_id;
  logic [ketq_pkg::EXP_W-1:0]  expiry_ms;
  logic [ketq_pkg::HND_W-1:0]  payload_handle;
  logic [ketq_pkg::EXP_W-1:0]  now_ms;

  modport source (
    output valid, action, msg_id, expiry_ms, payload_handle, now_ms,
    input  ready
  );
  modport sink (
    input  valid, action, msg_id, expiry_ms, payload_handle, now_ms,
    output ready
  );
endinterface

FILE: rtl/core/ketq_out_if.sv
// response channel: valid/ready plus one response word
interface ketq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [ketq_pkg::ID_W-1:0]   out_id;
  logic [ketq_pkg::HND_W-1:0]  out_handle;
  logic [ketq_pkg::EXP_W-1:0]  out_expiry;
  logic [ketq_pkg::DROP_W-1:0] dropped_count;

  modport source (
    output valid, status, out_id, out_handle, out_expiry, dropped_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_id, out_handle, out_expiry, dropped_count,
    output ready
  );
endinterface

FILE: rtl/core/keyed_expiring_tx_queue.sv
// keyed expiring transmit queue: top level with sequencer, valid bits and response register
// table walks: a remove takes one pass; a get front takes one more per expired head purged
//   enqueue: one pass per smallest-id eviction, then one to find its id or a free slot
// one request is served at a time, with a single table walker and comparator; a new request
// is taken only once the sequencer is idle again, and it is taken even
// while the previous response still waits on the output register
// reset (synchronous, active low) clears valid bits, count, sequencer and sets capacity to 16
module keyed_expiring_tx_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ketq_pkg::CAP_W-1:0] cfg_wdata,
  ketq_in_if.sink                    in_ch,
  ketq_out_if.source                 out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVCHK,
    ST_EVSCAN,
    ST_ENQFIND,
    ST_REM,
    ST_GET,
    ST_OUT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ketq_pkg::CAP_W-1:0]    cap_r;
  logic [ketq_pkg::CNT_W-1:0]    cap_eff;
  logic [ketq_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [ketq_pkg::DEPTH-1:0]    valid_r, valid_nxt;
  logic [ketq_pkg::DROP_W-1:0]   dropped_r, dropped_nxt;
  logic                          res_status_r, res_status_nxt;
  ketq_pkg::entry_t              res_ent_r, res_ent_nxt;

  // latched request word
  logic [ketq_pkg::ID_W-1:0]     id_r;
  logic [ketq_pkg::EXP_W-1:0]    exp_r;
  logic [ketq_pkg::HND_W-1:0]    handle_r;
  logic [ketq_pkg::EXP_W-1:0]    now_r;

  // response register
  logic                          out_valid_r;
  logic                          out_status_r;
  ketq_pkg::entry_t              out_ent_r;
  logic [ketq_pkg::DROP_W-1:0]   out_dropped_r;
  logic                          out_load;

  logic                          in_fire;
  logic                          use_chk;
  logic                          head_live;

  ketq_pkg::scan_cmd_t           scan_cmd;
  ketq_pkg::scan_res_t           scan_res;
  logic [ketq_pkg::IDX_W-1:0]    mem_raddr;
  ketq_pkg::entry_t              mem_rdata;
  logic                          mem_we;
  logic [ketq_pkg::IDX_W-1:0]    mem_waddr;
  ketq_pkg::entry_t              mem_wdata;
  ketq_pkg::cmp_op_t             scan_op;
  ketq_pkg::cmp_op_t             cmp_op;
  ketq_pkg::cmp_res_t            cmp_res;

  ketq_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ketq_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (scan_cmd),
    .valid_vec (valid_r),
    .raddr     (mem_raddr),
    .rdata     (mem_rdata),
    .cmp_op    (scan_op),
    .cmp_res   (cmp_res),
    .res       (scan_res)
  );

  // one comparator: id compares during a walk, head expiry check on the decision cycle
  ketq_cmp u_cmp (
    .op  (cmp_op),
    .res (cmp_res)
  );

  assign cmp_op.a = use_chk ? now_r : scan_op.a;
  assign cmp_op.b = use_chk ? scan_res.ent.expiry : scan_op.b;

  // live head: never expires, or expiry later than now
  assign head_live = (scan_res.ent.expiry == '0) || cmp_res.lt;

  // capacity zero acts as one, above the table size saturates
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = ketq_pkg::CNT_W'(1);
    end else if (32'(cap_r) > ketq_pkg::DEPTH) begin
      cap_eff = ketq_pkg::CNT_W'(ketq_pkg::DEPTH);
    end else begin
      cap_eff = ketq_pkg::CNT_W'(cap_r);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    valid_nxt      = valid_r;
    dropped_nxt    = dropped_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    scan_cmd.start = 1'b0;
    scan_cmd.mode  = ketq_pkg::SCAN_MIN;
    scan_cmd.key   = id_r;
    mem_we         = 1'b0;
    mem_waddr      = scan_res.slot;
    mem_wdata.id     = id_r;
    mem_wdata.expiry = exp_r;
    mem_wdata.handle = handle_r;
    use_chk        = 1'b0;
    out_load       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          dropped_nxt = '0;
          res_ent_nxt = '0;
          case (in_ch.action)
            ketq_pkg::ACT_ENQ: begin
              state_nxt = ST_EVCHK;
            end
            ketq_pkg::ACT_REM: begin
              scan_cmd.start = 1'b1;
              scan_cmd.mode  = ketq_pkg::SCAN_FIND;
              scan_cmd.key   = in_ch.msg_id;
              state_nxt      = ST_REM;
            end
            ketq_pkg::ACT_GET: begin
              scan_cmd.start = 1'b1;
              state_nxt      = ST_GET;
            end
            default: begin
              // unused code: nothing touched, miss reported
              res_status_nxt = ketq_pkg::STAT_MISS;
              state_nxt      = ST_OUT;
            end
          endcase
        end
      end

      ST_EVCHK: begin
        scan_cmd.start = 1'b1;
        if (count_r >= cap_eff) begin
          state_nxt = ST_EVSCAN;
        end else begin
          scan_cmd.mode = ketq_pkg::SCAN_FIND;
          state_nxt     = ST_ENQFIND;
        end
      end

      ST_EVSCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            valid_nxt[scan_res.slot] = 1'b0;
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
            dropped_nxt = dropped_r + 1'b1;
          end else begin
            count_nxt = '0;
          end
          state_nxt = ST_EVCHK;
        end
      end

      ST_ENQFIND: begin
        if (scan_res.done) begin
          // same id overwrites in place, otherwise the first free slot
          if (scan_res.hit) begin
            mem_we = 1'b1;
          end else if (scan_res.free_hit) begin
            mem_we    = 1'b1;
            mem_waddr = scan_res.free_slot;
            valid_nxt[scan_res.free_slot] = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          res_status_nxt = ketq_pkg::STAT_OK;
          state_nxt      = ST_OUT;
        end
      end

      ST_REM: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            valid_nxt[scan_res.slot] = 1'b0;
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
            res_status_nxt = ketq_pkg::STAT_OK;
          end else begin
            res_status_nxt = ketq_pkg::STAT_MISS;
          end
          state_nxt = ST_OUT;
        end
      end

      ST_GET: begin
        if (scan_res.done) begin
          if (!scan_res.hit) begin
            res_status_nxt = ketq_pkg::STAT_MISS;
            state_nxt      = ST_OUT;
          end else begin
            use_chk = 1'b1;
            if (head_live) begin
              res_status_nxt = ketq_pkg::STAT_OK;
              res_ent_nxt    = scan_res.ent;
              state_nxt      = ST_OUT;
            end else begin
              // expired head: purge and walk again for the next smallest id
              valid_nxt[scan_res.slot] = 1'b0;
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
              dropped_nxt    = dropped_r + 1'b1;
              scan_cmd.start = 1'b1;
            end
          end
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= ketq_pkg::CAP_W'(ketq_pkg::CAP_RESET);
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end

    dropped_r    <= dropped_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    if (in_fire) begin
      id_r     <= in_ch.msg_id;
      exp_r    <= in_ch.expiry_ms;
      handle_r <= in_ch.payload_handle;
      now_r    <= in_ch.now_ms;
    end
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_ent_r     <= res_ent_r;
      out_dropped_r <= dropped_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.out_id        = out_ent_r.id;
  assign out_ch.out_handle    = out_ent_r.handle;
  assign out_ch.out_expiry    = out_ent_r.expiry;
  assign out_ch.dropped_count = out_dropped_r;

  // count tracks the valid bits whenever the sequencer rests
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> $countones(valid_r) == int'(count_r))
    else $error("entry count out of step with valid bits");

  // an enqueue never leaves more entries than the effective capacity
  a_enq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ENQFIND && scan_res.done) |=> count_r <= $past(cap_eff))
    else $error("enqueue left table above capacity");

  // a walk only finishes while a request is being served
  a_scan_owned: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> (state_r != ST_IDLE && state_r != ST_OUT && state_r != ST_EVCHK))
    else $error("table walk finished with no request in flight");

  // response register is loaded only when empty or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_ent_r) && $stable(out_status_r))
    else $error("pending response overwritten");

endmodule

FILE: rtl/core/ketq_mem.sv
// entry storage: one write port, one registered read port
module ketq_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ketq_pkg::IDX_W-1:0] waddr,
  input  ketq_pkg::entry_t           wdata,
  input  logic [ketq_pkg::IDX_W-1:0] raddr,
  output ketq_pkg::entry_t           rdata
);

  ketq_pkg::entry_t mem_r [ketq_pkg::DEPTH];
  ketq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ketq_cmp.sv
// shared magnitude comparator, one subtract
module ketq_cmp (
  input  ketq_pkg::cmp_op_t  op,
  output ketq_pkg::cmp_res_t res
);

  logic [ketq_pkg::CMP_W:0] diff;

  assign diff   = {1'b0, op.a} - {1'b0, op.b};
  assign res.lt = diff[ketq_pkg::CMP_W];
  assign res.eq = (diff[ketq_pkg::CMP_W-1:0] == '0);

endmodule

FILE: rtl/core/ketq_scan.sv
// table walker: one slot a cycle, min-id or id-match search plus first free slot
module ketq_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ketq_pkg::scan_cmd_t         cmd,
  input  logic [ketq_pkg::DEPTH-1:0]  valid_vec,
  output logic [ketq_pkg::IDX_W-1:0]  raddr,
  input  ketq_pkg::entry_t            rdata,
  output ketq_pkg::cmp_op_t           cmp_op,
  input  ketq_pkg::cmp_res_t          cmp_res,
  output ketq_pkg::scan_res_t         res
);

  logic                        active_r;
  logic [ketq_pkg::IDX_W-1:0]  cnt_r;
  ketq_pkg::scan_mode_t        mode_r;
  logic [ketq_pkg::ID_W-1:0]   key_r;
  // one stage behind the address, lines up with the memory read
  logic                        p_vld_r;
  logic                        p_last_r;
  logic                        p_used_r;
  logic [ketq_pkg::IDX_W-1:0]  p_idx_r;
  logic                        best_hit_r;
  logic [ketq_pkg::IDX_W-1:0]  best_slot_r;
  ketq_pkg::entry_t            best_ent_r;
  logic                        free_hit_r;
  logic [ketq_pkg::IDX_W-1:0]  free_slot_r;
  logic                        done_r;
  logic                        take;
  logic                        last;

  assign raddr = cnt_r;
  assign last  = (cnt_r == ketq_pkg::IDX_W'(ketq_pkg::DEPTH - 1));

  assign cmp_op.a = ketq_pkg::CMP_W'(rdata.id);
  assign cmp_op.b = (mode_r == ketq_pkg::SCAN_MIN) ? ketq_pkg::CMP_W'(best_ent_r.id)
                                                   : ketq_pkg::CMP_W'(key_r);

  always_comb begin
    take = 1'b0;
    if (p_vld_r && p_used_r) begin
      case (mode_r)
        ketq_pkg::SCAN_MIN:  take = !best_hit_r || cmp_res.lt;
        ketq_pkg::SCAN_FIND: take = !best_hit_r && cmp_res.eq;
        default:             take = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      p_vld_r  <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (cmd.start) begin
        active_r <= 1'b1;
      end else if (active_r && last) begin
        active_r <= 1'b0;
      end
      p_vld_r <= active_r;
      done_r  <= p_vld_r && p_last_r;
    end

    if (cmd.start) begin
      cnt_r      <= '0;
      mode_r     <= cmd.mode;
      key_r      <= cmd.key;
      best_hit_r <= 1'b0;
      free_hit_r <= 1'b0;
    end else begin
      if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (take) begin
        best_hit_r  <= 1'b1;
        best_slot_r <= p_idx_r;
        best_ent_r  <= rdata;
      end
      if (p_vld_r && !p_used_r && !free_hit_r) begin
        free_hit_r  <= 1'b1;
        free_slot_r <= p_idx_r;
      end
    end

    p_last_r <= last;
    p_used_r <= valid_vec[cnt_r];
    p_idx_r  <= cnt_r;
  end

  assign res.done      = done_r;
  assign res.hit       = best_hit_r;
  assign res.slot      = best_slot_r;
  assign res.ent       = best_ent_r;
  assign res.free_hit  = free_hit_r;
  assign res.free_slot = free_slot_r;

endmodule

FILE: sim/ketq_tb_pkg.sv
// request and reply words for the transmit queue bench, plus the table mirror that predicts replies
package ketq_tb_pkg;
  import ketq_pkg::*;

  localparam logic [ACT_W-1:0] ACT_BAD = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  msg_id;
    logic [EXP_W-1:0] expiry_ms;
    logic [HND_W-1:0] payload_handle;
    logic [EXP_W-1:0] now_ms;
  } request_t;

  typedef struct packed {
    logic              status;
    logic [ID_W-1:0]   out_id;
    logic [HND_W-1:0]  out_handle;
    logic [EXP_W-1:0]  out_expiry;
    logic [DROP_W-1:0] dropped_count;
  } reply_t;

  typedef bit [ID_W-1:0] id_key_t;

  class tx_table_mirror;
    entry_t           held[id_key_t];
    logic [CAP_W-1:0] capacity;
    reply_t           due_replies[$];
    int unsigned      errors;
    int unsigned      drops_seen;
    int unsigned      replies_checked;

    function new();
      capacity        = CAP_RESET[CAP_W-1:0];
      errors          = 0;
      drops_seen      = 0;
      replies_checked = 0;
    endfunction

    // work out the reply to one accepted request and queue it
    function void take_request(request_t rq);
      reply_t      rp;
      id_key_t     key;
      int unsigned lim;
      int unsigned drops;
      rp        = '0;
      rp.status = STAT_MISS;
      drops     = 0;
      case (rq.action)
        ACT_ENQ: begin
          // capacity zero acts as one, anything past the table size as the full table
          lim = (capacity == 0) ? 1 : (capacity > DEPTH) ? DEPTH : capacity;
          // smallest ids go first, even when the id is already held
          while (held.num() >= lim) begin
            void'(held.first(key));
            held.delete(key);
            drops++;
          end
          held[rq.msg_id] = '{id: rq.msg_id, expiry: rq.expiry_ms, handle: rq.payload_handle};
          rp.status = STAT_OK;
        end
        ACT_REM: begin
          if (held.exists(rq.msg_id)) begin
            held.delete(rq.msg_id);
            rp.status = STAT_OK;
          end
        end
        ACT_GET: begin
          while (held.first(key)) begin
            if (held[key].expiry == '0 || held[key].expiry > rq.now_ms) begin
              rp.status     = STAT_OK;
              rp.out_id     = held[key].id;
              rp.out_handle = held[key].handle;
              rp.out_expiry = held[key].expiry;
              break;
            end
            held.delete(key);
            drops++;
          end
        end
        default: ;
      endcase
      rp.dropped_count = drops[DROP_W-1:0];
      drops_seen += drops;
      due_replies.push_back(rp);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      replies_checked++;
      if (due_replies.size() == 0) begin
        $error("reply word with nothing expected: status %0d id %0h", got.status, got.out_id);
        errors++;
        return;
      end
      want = due_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.out_id !== want.out_id) begin
        $error("out_id: expected %0h, got %0h", want.out_id, got.out_id);
        errors++;
      end
      if (got.out_handle !== want.out_handle) begin
        $error("out_handle: expected %0h, got %0h", want.out_handle, got.out_handle);
        errors++;
      end
      if (got.out_expiry !== want.out_expiry) begin
        $error("out_expiry: expected %0h, got %0h", want.out_expiry, got.out_expiry);
        errors++;
      end
      if (got.dropped_count !== want.dropped_count) begin
        $error("dropped_count: expected %0d, got %0d", want.dropped_count, got.dropped_count);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: sim/keyed_expiring_tx_queue_tb.sv
// bench for the keyed expiring transmit queue: directed and random requests, checked reply by reply
module keyed_expiring_tx_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ketq_pkg::*;
  import ketq_tb_pkg::*;

  localparam int PERIOD      = 10;
  localparam int ITEMS       = 1450;
  localparam int PHASES      = 8;
  // settle time after the last reply, longer than a remove's table walk to cover any tail work
  localparam int SETTLE      = DEPTH + 8;
  // watchdog limit: outlasts the worst single request (64 evictions or purges) plus output stalls
  localparam int STALL_LIMIT = 40000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  ketq_in_if  in_ch ();
  ketq_out_if out_ch ();

  tx_table_mirror   board;
  bit               calm;          // no idling on either side while set
  int unsigned      sent;
  int unsigned      act_count[4];
  int unsigned      quiet_cycles;
  logic [EXP_W-1:0] clock_ms;      // running notion of "now" for expiries and gets

  keyed_expiring_tx_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #(PERIOD / 2) clk = ~clk;

  // reply side: check on handshake, then pick ready for the next cycle
  always @(posedge clk) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      board.check_reply('{status: out_ch.status, out_id: out_ch.out_id,
                          out_handle: out_ch.out_handle, out_expiry: out_ch.out_expiry,
                          dropped_count: out_ch.dropped_count});
    end
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
  end

  // watchdog: too long with no word moving on either channel ends the run
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("keyed_expiring_tx_queue verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic request_t word_of(logic [ACT_W-1:0] a, logic [ID_W-1:0] id,
                                       logic [EXP_W-1:0] ex, logic [HND_W-1:0] h,
                                       logic [EXP_W-1:0] nw);
    return '{action: a, msg_id: id, expiry_ms: ex, payload_handle: h, now_ms: nw};
  endfunction

  function automatic logic [EXP_W-1:0] wide48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[EXP_W-1:0];
  endfunction

  // mostly ids from a narrow window so removes and overwrites hit,
  // expiries around the running clock so gets purge now and then
  function automatic request_t random_word(logic [ID_W-1:0] base, int unsigned span);
    request_t    rq;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    rq.action = (pick < 45) ? ACT_ENQ : (pick < 68) ? ACT_REM : (pick < 95) ? ACT_GET : ACT_BAD;
    if ($urandom_range(0, 9) == 0) begin
      rq.msg_id = ID_W'($urandom);
    end else begin
      rq.msg_id = ID_W'(base + $urandom_range(0, span));
    end
    rq.payload_handle = HND_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      rq.expiry_ms = '0;
    end else if (pick < 85) begin
      rq.expiry_ms = clock_ms + $urandom_range(1, 400);
    end else if (pick < 95) begin
      // already expired when it goes in
      rq.expiry_ms = clock_ms - $urandom_range(0, 60);
    end else begin
      rq.expiry_ms = wide48();
    end
    if (rq.action == ACT_GET) begin
      clock_ms = clock_ms + $urandom_range(0, 40);
    end
    // rare random wide now, mostly far past the clock, lets gets purge many expiring heads
    rq.now_ms = ($urandom_range(0, 49) == 0) ? wide48() : clock_ms;
    return rq;
  endfunction

  // offer one request word and hold it until the block takes it
  task automatic send_word(input request_t rq);
    if (!calm) begin
      while ($urandom_range(0, 99) < 28) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= rq.action;
    in_ch.msg_id         <= rq.msg_id;
    in_ch.expiry_ms      <= rq.expiry_ms;
    in_ch.payload_handle <= rq.payload_handle;
    in_ch.now_ms         <= rq.now_ms;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.take_request(rq);
    act_count[rq.action]++;
    sent++;
  endtask

  // hold off the sender until every reply is back, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    board.capacity = v;
    cfg_we <= 1'b0;
  endtask

  // fill the whole table with distinct ids, all with nonzero expiry
  task automatic fill_table(input logic [ID_W-1:0] first_id);
    for (int i = 0; i < DEPTH; i++) begin
      send_word(word_of(ACT_ENQ, ID_W'(first_id + 3 * i), clock_ms + 1 + i,
                        HND_W'($urandom), '0));
    end
  endtask

  initial begin
    request_t         plan[$];
    logic [CAP_W-1:0] caps[PHASES];
    int unsigned      budget;
    int unsigned      lim;
    int unsigned      span;
    logic [ID_W-1:0]  base;

    clk                  = 1'b0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.action         = '0;
    in_ch.msg_id         = '0;
    in_ch.expiry_ms      = '0;
    in_ch.payload_handle = '0;
    in_ch.now_ms         = '0;
    out_ch.ready         = 1'b0;
    calm                 = 1'b0;
    sent                 = 0;
    quiet_cycles         = 0;
    clock_ms             = 48'd1000;
    foreach (act_count[i]) act_count[i] = 0;
    board = new();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset capacity of 16
    // empty table: get and remove both miss, unused code changes nothing
    plan.push_back(word_of(ACT_GET, '0, '0, '0, '0));
    plan.push_back(word_of(ACT_REM, 31'd7, '0, '0, '0));
    plan.push_back(word_of(ACT_BAD, '1, '1, '1, '1));
    plan.push_back(word_of(ACT_BAD, '0, '0, '0, '0));
    // field extremes, then an overwrite of an id already held
    plan.push_back(word_of(ACT_ENQ, '0, '0, '0, '1));
    plan.push_back(word_of(ACT_ENQ, '1, '1, '1, '0));
    plan.push_back(word_of(ACT_ENQ, 31'd5, 48'd100, 16'h1234, '0));
    plan.push_back(word_of(ACT_ENQ, 31'd5, 48'd50, 16'habcd, '0));
    // zero expiry never expires, even at the latest time
    plan.push_back(word_of(ACT_GET, '0, '0, '0, '1));
    plan.push_back(word_of(ACT_REM, '0, '0, '0, '0));
    plan.push_back(word_of(ACT_REM, '0, '0, '0, '0));
    // expiry equal to now counts as expired
    plan.push_back(word_of(ACT_GET, '0, '0, '0, 48'd49));
    plan.push_back(word_of(ACT_GET, '0, '0, '0, 48'd50));
    plan.push_back(word_of(ACT_GET, '0, '0, '0, 48'hffff_ffff_fffe));
    plan.push_back(word_of(ACT_GET, '0, '0, '0, '1));
    plan.push_back(word_of(ACT_REM, '1, '0, '0, '0));
    // alternating bit patterns through every field
    plan.push_back(word_of(ACT_ENQ, 31'h2aaa_aaaa, 48'haaaa_aaaa_aaaa, 16'haaaa,
                           48'h5555_5555_5555));
    plan.push_back(word_of(ACT_ENQ, 31'h5555_5555, 48'h5555_5555_5555, 16'h5555,
                           48'haaaa_aaaa_aaaa));
    plan.push_back(word_of(ACT_GET, 31'h5555_5555, '0, '0, 48'h5555_5555_5555));
    plan.push_back(word_of(ACT_GET, 31'h2aaa_aaaa, '0, '0, 48'haaaa_aaaa_aaaa));
    foreach (plan[i]) send_word(plan[i]);

    // capacity settings: full table, one, zero (acts as one), past the table size,
    // small with no idling anywhere, past again, middling, then a random one
    caps     = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd100, 7'd40, 7'd16};
    caps[7]  = CAP_W'($urandom_range(2, 63));
    for (int ph = 0; ph < PHASES; ph++) begin
      set_capacity(caps[ph]);
      calm = (ph == 4);
      base = ID_W'($urandom_range(0, 32'h7fff_0000));
      if (ph == 0) begin
        // a full table purged in one get, then filled again for the next setting
        fill_table(base);
        send_word(word_of(ACT_GET, '0, '0, '0, '1));
        fill_table(base + 1);
      end
      if (ph == 1) begin
        // capacity dropped to one with a full table: one enqueue evicts everything
        send_word(word_of(ACT_ENQ, base, '0, 16'h5a5a, '0));
      end
      budget = (ITEMS > sent) ? (ITEMS - sent) / (PHASES - ph) : 0;
      lim    = (caps[ph] == 0) ? 1 : (caps[ph] > DEPTH) ? DEPTH : caps[ph];
      span   = 2 * lim + 4;
      repeat (budget) send_word(random_word(base, span));
    end

    drain();
    calm = 1'b0;

    $display("sent %0d request words: %0d enqueue, %0d remove, %0d get, %0d unused code;",
             sent, act_count[ACT_ENQ], act_count[ACT_REM], act_count[ACT_GET],
             act_count[ACT_BAD]);
    $display("%0d capacity settings, checked %0d reply words, %0d evicted or purged, %0d mismatches",
             PHASES + 1, board.replies_checked, board.drops_seen, board.errors);
    if (board.errors == 0) begin
      $display("keyed_expiring_tx_queue verification clean");
    end else begin
      $display("keyed_expiring_tx_queue verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ketq_pkg.sv
rtl/core/ketq_in_if.sv
rtl/core/ketq_out_if.sv
rtl/core/ketq_mem.sv
rtl/core/ketq_cmp.sv
rtl/core/ketq_scan.sv
rtl/core/keyed_expiring_tx_queue.sv
sim/ketq_tb_pkg.sv
sim/keyed_expiring_tx_queue_tb.sv
